// ===== rtl/dprm_pkg.sv =====
// ----------------------------------------------------------------------------
// DNA pattern matcher package
// Shared types, constants and base-coding functions for the pattern matcher.
// ----------------------------------------------------------------------------
package dprm_pkg;

	// Default for the largest supported pattern length.
	localparam int PATTERN_MAX_DEF = 64;

	// Register map and port widths.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int LEN_W   = 7;
	localparam int POS_W   = 16;
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);
	localparam logic [POS_W-1:0] POS_MAX   = '1;

	// Register index taken from the word address.
	localparam logic REG_PATTERN_LENGTH = 1'b0;

	// Item commands.
	localparam logic CMD_PATTERN = 1'b0;
	localparam logic CMD_TEXT    = 1'b1;

	// ASCII base characters.
	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_G = 8'h47;
	localparam logic [7:0] CHAR_T = 8'h54;

	// A stored base: valid bit on top, 2-bit code below (A=0, C=1, G=2, T=3).
	typedef logic [2:0] entry_t;
	localparam entry_t ENTRY_INVALID = 3'b000;
	localparam entry_t ENTRY_A       = 3'b100;
	localparam entry_t ENTRY_C       = 3'b101;
	localparam entry_t ENTRY_G       = 3'b110;
	localparam entry_t ENTRY_T       = 3'b111;

	typedef struct packed {
		logic       cmd;
		logic [7:0] symbol;
		logic [5:0] pattern_index;
		logic       last_of_text;
	} item_t;

	typedef struct packed {
		logic             direct_hit;
		logic             reverse_hit;
		logic [POS_W-1:0] start_position;
		logic             bad_symbol;
	} result_t;

	// Control handed to every window cell.
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	// Compare status returned by every window cell.
	typedef struct packed {
		logic direct;
		logic reverse;
	} cell_match_t;

	function automatic entry_t encode_base(input logic [7:0] sym);
		entry_t e;
		case (sym)
			CHAR_A:  e = ENTRY_A;
			CHAR_C:  e = ENTRY_C;
			CHAR_G:  e = ENTRY_G;
			CHAR_T:  e = ENTRY_T;
			default: e = ENTRY_INVALID;
		endcase
		return e;
	endfunction

	// A<->T and C<->G is an inversion of the 2-bit code.
	function automatic entry_t complement_entry(input entry_t e);
		return e[2] ? {1'b1, ~e[1:0]} : ENTRY_INVALID;
	endfunction

endpackage

// ===== rtl/dprm_cell.sv =====
// ----------------------------------------------------------------------------
// DNA pattern matcher window cell
// Holds one text base of the sliding window and compares the base that
// enters it against the aligned pattern base and the complement base.
// ----------------------------------------------------------------------------
module dprm_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dprm_pkg::cell_ctrl_t ctrl,
	input  dprm_pkg::entry_t     base_in,
	input  dprm_pkg::entry_t     pat,
	input  dprm_pkg::entry_t     rc,
	input  logic                 active,
	output dprm_pkg::entry_t     base_out,
	output dprm_pkg::cell_match_t match
);
	import dprm_pkg::*;

	entry_t base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= ENTRY_INVALID;
		end else if (ctrl.shift) begin
			base_q <= ctrl.clear ? ENTRY_INVALID : base_in;
		end
	end

	// Cells beyond the pattern length always agree.
	assign match.direct  = !active || (base_in[2] && (base_in == pat));
	assign match.reverse = !active || (base_in[2] && (base_in == rc));
	assign base_out      = base_q;

endmodule

// ===== rtl/dprm_store.sv =====
// ----------------------------------------------------------------------------
// DNA pattern matcher pattern store
// Keeps the pattern in reversed order and its complement, and presents the
// pattern aligned to the current length for the window cells.
// ----------------------------------------------------------------------------
module dprm_store #(
	parameter int PATTERN_MAX = dprm_pkg::PATTERN_MAX_DEF,
	parameter int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [5:0]       wr_idx,
	input  dprm_pkg::entry_t wr_entry,
	input  logic [IDX_W-1:0] align_shift,
	output dprm_pkg::entry_t pat_aligned [PATTERN_MAX],
	output dprm_pkg::entry_t rc_entry [PATTERN_MAX]
);
	import dprm_pkg::*;

	localparam int VEC_W = PATTERN_MAX * 3;
	localparam int SH_W  = IDX_W + 2;

	logic [VEC_W-1:0] rev_q;
	logic [VEC_W-1:0] rev_d;
	logic [VEC_W-1:0] aligned_q;
	entry_t           rc_q [PATTERN_MAX];
	logic             in_range;
	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] rev_idx;
	logic [SH_W-1:0]  bit_shift;

	assign in_range  = ({26'd0, wr_idx} < 32'(PATTERN_MAX));
	assign idx       = IDX_W'(wr_idx);
	assign rev_idx   = IDX_W'(PATTERN_MAX - 1) - idx;
	assign bit_shift = SH_W'(align_shift) * SH_W'(3);

	// Entry k of the reversed copy is pattern base PATTERN_MAX-1-k, so a
	// right shift by PATTERN_MAX-length lines base length-1-j up with cell j.
	always_comb begin
		rev_d = rev_q;
		if (wr_en && in_range) begin
			rev_d[3*rev_idx +: 3] = wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_q     <= '0;
			aligned_q <= '0;
			for (int i = 0; i < PATTERN_MAX; i++) begin
				rc_q[i] <= ENTRY_INVALID;
			end
		end else begin
			rev_q     <= rev_d;
			aligned_q <= rev_d >> bit_shift;
			if (wr_en && in_range) begin
				rc_q[idx] <= complement_entry(wr_entry);
			end
		end
	end

	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_out
		assign pat_aligned[j] = aligned_q[3*j +: 3];
		assign rc_entry[j]    = rc_q[j];
	end

endmodule

// ===== rtl/dna_pattern_and_revcomp_matcher.sv =====
// ----------------------------------------------------------------------------
// DNA pattern and reverse-complement matcher
// Streams text bases through a chain of window cells and reports exact
// matches of the loaded pattern and of its reverse complement.
// ----------------------------------------------------------------------------
// The result of a request is registered and offered in the cycle after it is accepted.
// Throughput: one request per cycle while the result side keeps up; every window cell compares in parallel,
// and the output register lets a new request in while the result is drained.
// Reset clears the pattern stores and the window to invalid, the text
// position to zero and pattern_length to one; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dna_pattern_and_revcomp_matcher #(
	parameter int PATTERN_MAX = dprm_pkg::PATTERN_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request channel.
	input  logic                           item_valid,
	output logic                           item_ready,
	input  dprm_pkg::item_t                item,
	// Result channel.
	output logic                           result_valid,
	input  logic                           result_ready,
	output dprm_pkg::result_t              result,
	// Configuration port.
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dprm_pkg::PADDR_W-1:0]   paddr,
	input  logic [dprm_pkg::PDATA_W-1:0]   pwdata,
	output logic [dprm_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	import dprm_pkg::*;

	// Width of a clamped length; wide enough to hold PATTERN_MAX itself.
	localparam int MLW_RAW = $clog2(PATTERN_MAX + 1);
	localparam int MLW     = (MLW_RAW > LEN_W) ? MLW_RAW : LEN_W;
	localparam int IDX_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	// ------------------------------------------------------------------
	// Configuration register. Word addresses select the register; the
	// byte offset bits are ignored.
	// ------------------------------------------------------------------
	logic [LEN_W-1:0] length_q;
	logic [LEN_W-1:0] length_d;
	logic             cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		length_d = length_q;
		if (cfg_write && (paddr[2] == REG_PATTERN_LENGTH)) begin
			length_d = pwdata[LEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= LEN_RESET;
		end else begin
			length_q <= length_d;
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PATTERN_LENGTH) begin
			prdata = PDATA_W'(length_q);
		end
	end

	// Effective length: zero acts as one, anything above the window depth
	// acts as the full depth.
	logic [MLW-1:0]   len_ext;
	logic [MLW-1:0]   m_eff;
	logic [MLW-1:0]   len_next_ext;
	logic [MLW-1:0]   m_next;
	logic [IDX_W-1:0] align_shift;

	assign len_ext      = MLW'(length_q);
	assign len_next_ext = MLW'(length_d);

	always_comb begin
		m_eff = len_ext;
		if (len_ext == '0) begin
			m_eff = MLW'(1);
		end else if (len_ext > MLW'(PATTERN_MAX)) begin
			m_eff = MLW'(PATTERN_MAX);
		end
	end

	// The aligned pattern copy is registered, so its shift follows the
	// length that is in force after the coming clock edge. A request right
	// after a length write then sees the pattern lined up for the new length.
	always_comb begin
		m_next = len_next_ext;
		if (len_next_ext == '0) begin
			m_next = MLW'(1);
		end else if (len_next_ext > MLW'(PATTERN_MAX)) begin
			m_next = MLW'(PATTERN_MAX);
		end
	end

	assign align_shift = IDX_W'(MLW'(PATTERN_MAX) - m_next);

	// ------------------------------------------------------------------
	// Handshake. A request is taken whenever the output register is empty
	// or is being drained in the same cycle.
	// ------------------------------------------------------------------
	logic    in_fire;
	logic    is_text;
	entry_t  code;
	logic    out_valid_q;
	result_t out_rsp_q;

	assign item_ready = !out_valid_q || result_ready;
	assign in_fire    = item_valid && item_ready;
	assign is_text    = (item.cmd == CMD_TEXT);
	assign code       = encode_base(item.symbol);

	// ------------------------------------------------------------------
	// Pattern store: a pattern request writes one base and its complement.
	// ------------------------------------------------------------------
	entry_t pat_aligned [PATTERN_MAX];
	entry_t rc_entry [PATTERN_MAX];

	dprm_store #(
		.PATTERN_MAX (PATTERN_MAX),
		.IDX_W       (IDX_W)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (in_fire && !is_text),
		.wr_idx      (item.pattern_index),
		.wr_entry    (code),
		.align_shift (align_shift),
		.pat_aligned (pat_aligned),
		.rc_entry    (rc_entry)
	);

	// ------------------------------------------------------------------
	// Window chain. Cell 0 takes the newest base; every cell passes its base
	// to the next one on each text request. The last base of a text clears
	// the whole window after its own compare, so no match spans two texts.
	// ------------------------------------------------------------------
	cell_ctrl_t  cell_ctrl;
	entry_t      cell_base [PATTERN_MAX];
	cell_match_t cell_match [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] direct_vec;
	logic [PATTERN_MAX-1:0] reverse_vec;

	assign cell_ctrl.shift = in_fire && is_text;
	assign cell_ctrl.clear = item.last_of_text;

	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
		entry_t base_in;

		if (j == 0) begin : g_head
			assign base_in = code;
		end else begin : g_link
			assign base_in = cell_base[j-1];
		end

		dprm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.base_in  (base_in),
			.pat      (pat_aligned[j]),
			.rc       (rc_entry[j]),
			.active   (MLW'(j) < m_eff),
			.base_out (cell_base[j]),
			.match    (cell_match[j])
		);

		assign direct_vec[j]  = cell_match[j].direct;
		assign reverse_vec[j] = cell_match[j].reverse;
	end

	// ------------------------------------------------------------------
	// Text position and result assembly. The position counts bases of the
	// current text, saturates at its maximum, and restarts after the last.
	// ------------------------------------------------------------------
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_next;
	logic [POS_W-1:0] m_pos;
	logic             dhit;
	logic             rhit;
	result_t          rsp;

	assign pos_next = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);
	assign m_pos    = POS_W'(m_eff);
	assign dhit     = is_text && (&direct_vec);
	assign rhit     = is_text && (&reverse_vec);

	always_comb begin
		rsp.direct_hit     = dhit;
		rsp.reverse_hit    = rhit;
		rsp.bad_symbol     = !code[2];
		rsp.start_position = '0;
		if ((dhit || rhit) && (pos_next >= m_pos)) begin
			rsp.start_position = pos_next - m_pos + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_fire && is_text) begin
			pos_q <= item.last_of_text ? '0 : pos_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_rsp_q <= rsp;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_rsp_q;

`ifndef SYNTH
	// Any hit carries a real start position.
	a_hit_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.direct_hit || result.reverse_hit)
		|-> (result.start_position != '0))
		else $error("hit reported without a start position");

	// A hit needs the newest base to be a real base.
	a_hit_valid_base: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.direct_hit || result.reverse_hit)
		|-> !result.bad_symbol)
		else $error("hit reported on a bad symbol");

	// The last base of a text restarts the position count.
	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && is_text && item.last_of_text |=> (pos_q == '0))
		else $error("text position not cleared after end of text");

	// Inside a text the position advances by one until it saturates.
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && is_text && !item.last_of_text && (pos_q != POS_MAX)
		|=> (pos_q == $past(pos_q) + POS_W'(1)))
		else $error("text position did not advance");

	// An empty output register never blocks the request side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> item_ready)
		else $error("request stalled with an empty output register");
`endif

endmodule
